>>> design/ppou_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppou_pkg;

  localparam int unsigned PIXEL_WIDTH = 32;
  localparam int unsigned CHAN_WIDTH = 8;
  localparam int unsigned CFG_INDEX_WIDTH = 3;

  localparam logic [CHAN_WIDTH-1:0] CHAN_MAX = 8'hff;

  localparam logic [2:0] MODE_NEGATIVE = 3'd0;
  localparam logic [2:0] MODE_SET_OPACITY = 3'd1;
  localparam logic [2:0] MODE_KEY_OPACITY = 3'd2;
  localparam logic [2:0] MODE_REPLACE_COLOR = 3'd3;
  localparam logic [2:0] MODE_REPLACE_OPAQUE = 3'd4;
  localparam logic [2:0] MODE_PREMULTIPLY = 3'd5;

  localparam logic [1:0] LAYOUT_ARGB = 2'd0;
  localparam logic [1:0] LAYOUT_ABGR = 2'd1;
  localparam logic [1:0] LAYOUT_RGBA = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OP_MODE = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CHANNEL_LAYOUT = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_KEY_COLOR = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPLACEMENT_COLOR = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OPACITY_MAIN = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OPACITY_OTHER = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OPACITY_THRESHOLD = 3'd6;

  localparam logic [PIXEL_WIDTH-1:0] COLOR_MASK_ALPHA_HIGH = 32'h00ff_ffff;
  localparam logic [PIXEL_WIDTH-1:0] COLOR_MASK_ALPHA_LOW = 32'hffff_ff00;

endpackage

`default_nettype wire

>>> design/pixel_point_operation_unit.sv
// Pixel point operation unit for 32-bit pixels of four 8-bit channels.
// Input words arrive on pixel_in/last_in under in_valid/in_ready, and result
// words leave on pixel_out/last_out under out_valid/out_ready. Each input word
// gives exactly one output word, in order, and last_in is copied to last_out.
// The operation and channel layout come from registers written through the
// cfg_write/cfg_index/cfg_data port; they must be written by the user only
// while no word is in flight, which the block does not enforce, and a write to
// an index beyond the register list is ignored. The datapath is a three-stage
// pipeline: decode and compare, then the alpha products and mode selection,
// then rounding and the final merge. Throughput is one word per cycle while
// out_ready is high, bounded by the single pass through the stage registers.
// When the receiver holds out_ready low, the output stage keeps its word and
// the earlier stages keep filling any empty slots, so up to three words are
// held before in_ready falls. Reset empties the pipeline and returns every
// configuration register to its reset value (opacity registers to 255).
`timescale 1ns / 1ps
`default_nettype none

module pixel_point_operation_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] pixel_in,
  input  wire logic        last_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      pixel_out,
  output logic             last_out
);

  logic [2:0]  op_mode;
  logic [1:0]  channel_layout;
  logic [31:0] key_color;
  logic [31:0] replacement_color;
  logic [7:0]  opacity_main;
  logic [7:0]  opacity_other;
  logic [7:0]  opacity_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= ppou_pkg::MODE_NEGATIVE;
      channel_layout <= ppou_pkg::LAYOUT_ARGB;
      key_color <= '0;
      replacement_color <= '0;
      opacity_main <= ppou_pkg::CHAN_MAX;
      opacity_other <= ppou_pkg::CHAN_MAX;
      opacity_threshold <= ppou_pkg::CHAN_MAX;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ppou_pkg::REG_OP_MODE: op_mode <= cfg_data[2:0];
        ppou_pkg::REG_CHANNEL_LAYOUT: channel_layout <= cfg_data[1:0];
        ppou_pkg::REG_KEY_COLOR: key_color <= cfg_data;
        ppou_pkg::REG_REPLACEMENT_COLOR: replacement_color <= cfg_data;
        ppou_pkg::REG_OPACITY_MAIN: opacity_main <= cfg_data[7:0];
        ppou_pkg::REG_OPACITY_OTHER: opacity_other <= cfg_data[7:0];
        ppou_pkg::REG_OPACITY_THRESHOLD: opacity_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic        alpha_low;
  logic [31:0] color_mask;
  logic [31:0] alpha_mask;
  logic [31:0] main_field;
  logic [31:0] other_field;

  assign alpha_low = (channel_layout == ppou_pkg::LAYOUT_RGBA);
  assign color_mask = alpha_low ? ppou_pkg::COLOR_MASK_ALPHA_LOW
                                : ppou_pkg::COLOR_MASK_ALPHA_HIGH;
  assign alpha_mask = ~color_mask;
  assign main_field = alpha_low ? {24'd0, opacity_main} : {opacity_main, 24'd0};
  assign other_field = alpha_low ? {24'd0, opacity_other} : {opacity_other, 24'd0};

  logic en1;
  logic en2;
  logic en3;

  logic        s1_valid;
  logic [31:0] s1_pixel;
  logic        s1_last;
  logic [7:0]  s1_alpha;
  logic        s1_key_match;
  logic        s1_color_match;
  logic        s1_over_threshold;

  logic        s2_valid;
  logic        s2_last;
  logic [31:0] s2_result;
  logic        s2_premul;
  logic [15:0] s2_prod [3];

  logic [7:0]  in_alpha;
  logic [7:0]  s1_chan [3];
  logic [31:0] s2_result_next;
  logic [7:0]  s3_chan [3];
  logic [31:0] s3_premul_bits;
  logic [15:0] s3_round [3];

  assign en3 = !out_valid || out_ready;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign in_ready = en1;

  assign in_alpha = alpha_low ? pixel_in[7:0] : pixel_in[31:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_pixel <= pixel_in;
      s1_last <= last_in;
      s1_alpha <= in_alpha;
      s1_key_match <= (pixel_in == key_color);
      s1_color_match <= ((pixel_in & color_mask) == (key_color & color_mask));
      s1_over_threshold <= (in_alpha >= opacity_threshold);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_chan[i] = alpha_low ? s1_pixel[8*i+8 +: 8] : s1_pixel[8*i +: 8];
    end
  end

  always_comb begin
    unique case (op_mode)
      ppou_pkg::MODE_NEGATIVE: s2_result_next = s1_pixel ^ color_mask;
      ppou_pkg::MODE_SET_OPACITY: s2_result_next = (s1_pixel & color_mask) | main_field;
      ppou_pkg::MODE_KEY_OPACITY: begin
        s2_result_next = (s1_pixel & color_mask)
                       | (s1_color_match ? main_field : other_field);
      end
      ppou_pkg::MODE_REPLACE_COLOR: begin
        s2_result_next = s1_key_match ? replacement_color : s1_pixel;
      end
      ppou_pkg::MODE_REPLACE_OPAQUE: begin
        s2_result_next = s1_over_threshold ? replacement_color : s1_pixel;
      end
      ppou_pkg::MODE_PREMULTIPLY: s2_result_next = s1_pixel & alpha_mask;
      default: s2_result_next = s1_pixel;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      s2_last <= s1_last;
      s2_result <= s2_result_next;
      s2_premul <= (op_mode == ppou_pkg::MODE_PREMULTIPLY);
      for (int i = 0; i < 3; i++) begin
        s2_prod[i] <= 16'(s1_chan[i]) * 16'(s1_alpha);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_round[i] = s2_prod[i] + {8'd0, ppou_pkg::CHAN_MAX};
      s3_chan[i] = s3_round[i][15:8];
    end
    if (alpha_low) begin
      s3_premul_bits = {s3_chan[2], s3_chan[1], s3_chan[0], 8'd0};
    end else begin
      s3_premul_bits = {8'd0, s3_chan[2], s3_chan[1], s3_chan[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_valid) begin
      last_out <= s2_last;
      pixel_out <= s2_premul ? (s2_result | s3_premul_bits) : s2_result;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_ready |-> in_ready)
    else $error("input stalled while the output side was ready");

  assert property (@(posedge clk) disable iff (rst) !s1_valid |-> in_ready)
    else $error("input stalled with an empty first stage");

  assert property (@(posedge clk) $past(rst) |-> !out_valid && !s1_valid && !s2_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
